@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ACET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ACET_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/acet_pkg.sv @@
package acet_pkg;

    localparam int ID_BITS           = 6;
    localparam int COORD_BITS        = 16;
    localparam int SIZE_BITS         = COORD_BITS - 1;
    localparam int ROW_BITS          = 32;
    localparam int ROW_BIT_W         = $clog2(ROW_BITS);
    localparam int DEF_MAX_COLLIDERS = 64;

    localparam logic KIND_TEST  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

    typedef struct packed {
        logic                         kind;
        logic [ID_BITS-1:0]           first_id;
        logic [ID_BITS-1:0]           second_id;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic [SIZE_BITS-1:0]         first_w;
        logic [SIZE_BITS-1:0]         first_h;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic [SIZE_BITS-1:0]         second_w;
        logic [SIZE_BITS-1:0]         second_h;
    } req_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       overlapping;
    } res_t;

endpackage

@@ rtl/aabb_contact_event_tracker.sv @@
// AABB contact event tracker. A test request carries two collider ids and
// both boxes; one result (enter / stay / exit / none plus the raw overlap
// flag) comes out on result with done high for one cycle, after the
// stage 1, stage 2 and result registers. Tests are taken every cycle
// while busy is low; the result side has no backpressure, so every
// strobe must be captured when it appears. Touching bits live in a
// single-port-write, one-read RAM of 32-bit rows (MAX_COLLIDERS^2 / 32
// rows, 128 at the default); back-to-back tests on the same row are
// handled by forwarding the row written in the previous cycle. A clear
// request raises busy until the RAM has been swept to zero one row per
// cycle. The same sweep runs after reset, with busy high until it ends.
// Equal ids, or an id at or above MAX_COLLIDERS, give event none and
// leave the stored bits alone; overlapping still reports the box test.
module aabb_contact_event_tracker #(
    parameter int MAX_COLLIDERS = acet_pkg::DEF_MAX_COLLIDERS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  acet_pkg::req_t  request,
    output logic            done,
    output acet_pkg::res_t  result
);
    import acet_pkg::*;

    `include "assert_macros.svh"

    localparam int PAIRS  = MAX_COLLIDERS * MAX_COLLIDERS;
    localparam int ROWS   = (PAIRS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_AW + ROW_BIT_W;

    typedef logic [ROW_BITS-1:0] row_t;

    // touching bits, one row per 32 ordered pairs
    row_t mem [ROWS];

    logic accept;

    // stage 1: request held, box test, RAM read issued
    logic              s1_valid_reg;
    req_t              s1_req_reg;
    logic              s1_hit;
    logic              s1_pair_ok;
    logic [IDX_W-1:0]  s1_idx;
    logic [ROW_AW-1:0] s1_rd_row;

    // stage 2: RAM data back, event decided, row written
    logic                 s2_valid_reg;
    logic                 s2_clear_reg;
    logic                 s2_pair_ok_reg;
    logic                 s2_hit_reg;
    logic [ROW_AW-1:0]    s2_row_reg;
    logic [ROW_BIT_W-1:0] s2_bit_reg;
    row_t                 rdata_reg;
    row_t                 row_cur;
    row_t                 row_new;
    logic                 was_touching;
    logic [1:0]           s2_event;
    logic                 item_wr;

    // last write, for a read that hit the same row on the same edge
    logic              fwd_valid_reg;
    logic [ROW_AW-1:0] fwd_row_reg;
    row_t              fwd_data_reg;

    // clear sweep
    logic              clear_hold_reg;
    logic              clear_hold_next;
    logic              sweep_reg;
    logic              sweep_next;
    logic [ROW_AW-1:0] sweep_cnt_reg;
    logic [ROW_AW-1:0] sweep_cnt_next;
    logic              sweep_last;

    // RAM write port
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
    row_t              wr_data;

    logic done_reg;
    res_t result_reg;

    assign busy   = clear_hold_reg | sweep_reg;
    assign accept = start & ~busy;

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request;
        end
    end

    acet_overlap u_overlap (
        .request (s1_req_reg),
        .hit     (s1_hit)
    );

    assign s1_pair_ok = (s1_req_reg.kind == KIND_TEST)
                     && (s1_req_reg.first_id != s1_req_reg.second_id)
                     && (32'(s1_req_reg.first_id) < MAX_COLLIDERS)
                     && (32'(s1_req_reg.second_id) < MAX_COLLIDERS);

    assign s1_idx = IDX_W'(32'(s1_req_reg.first_id) * MAX_COLLIDERS
                         + 32'(s1_req_reg.second_id));

    // out-of-range ids never reach the RAM
    assign s1_rd_row = s1_pair_ok ? s1_idx[IDX_W-1:ROW_BIT_W] : '0;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            rdata_reg <= mem[s1_rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_clear_reg   <= (s1_req_reg.kind == KIND_CLEAR);
            s2_pair_ok_reg <= s1_pair_ok;
            s2_hit_reg     <= s1_hit;
            s2_row_reg     <= s1_rd_row;
            s2_bit_reg     <= s1_idx[ROW_BIT_W-1:0];
        end
    end

    // ---------------- stage 2 ----------------
    assign row_cur = (fwd_valid_reg && (fwd_row_reg == s2_row_reg)) ? fwd_data_reg : rdata_reg;
    assign was_touching = row_cur[s2_bit_reg];

    always_comb
    begin
        row_new             = row_cur;
        row_new[s2_bit_reg] = s2_hit_reg;
    end

    always_comb
    begin
        s2_event = EV_NONE;
        if (s2_pair_ok_reg)
        begin
            case ({s2_hit_reg, was_touching})
                2'b10:   s2_event = EV_ENTER;
                2'b11:   s2_event = EV_STAY;
                2'b01:   s2_event = EV_EXIT;
                default: s2_event = EV_NONE;
            endcase
        end
    end

    // only a change of state costs a write
    assign item_wr = s2_valid_reg && s2_pair_ok_reg && (s2_hit_reg != was_touching);

    // ---------------- clear sweep ----------------
    assign sweep_last = (sweep_cnt_reg == ROW_AW'(ROWS - 1));

    always_comb
    begin
        clear_hold_next = clear_hold_reg;
        sweep_next      = sweep_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        if (accept && (request.kind == KIND_CLEAR))
        begin
            clear_hold_next = 1'b1;
        end
        if (s2_valid_reg && s2_clear_reg)
        begin
            clear_hold_next = 1'b0;
            sweep_next      = 1'b1;
            sweep_cnt_next  = '0;
        end
        else if (sweep_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_last)
            begin
                sweep_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_hold_reg <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_cnt_reg  <= '0;
        end
        else
        begin
            clear_hold_reg <= clear_hold_next;
            sweep_reg      <= sweep_next;
            sweep_cnt_reg  <= sweep_cnt_next;
        end
    end

    // ---------------- RAM write and forward ----------------
    assign wr_en   = sweep_reg | item_wr;
    assign wr_row  = sweep_reg ? sweep_cnt_reg : s2_row_reg;
    assign wr_data = sweep_reg ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_row_reg  <= wr_row;
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            result_reg.event_res   <= s2_clear_reg ? EV_NONE : s2_event;
            result_reg.overlapping <= s2_clear_reg ? 1'b0 : s2_hit_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks ----------------
    `ACET_ASSERT(a_sweep_owns_ram, !(sweep_reg && item_wr), "test write during clear sweep")
    `ACET_ASSERT(a_one_bit_changes, item_wr |-> ($countones(row_new ^ row_cur) == 1), "test write touches more than one pair bit")
    `ACET_ASSERT(a_clear_result, (s2_valid_reg && s2_clear_reg) |=> (done && (result.event_res == EV_NONE) && !result.overlapping), "clear request gave a nonzero result")
    `ACET_ASSERT(a_touch_needs_hit, (done && ((result.event_res == EV_ENTER) || (result.event_res == EV_STAY))) |-> result.overlapping, "enter or stay without overlap")
    `ACET_ASSERT(a_clear_blocks, (accept && (request.kind == KIND_CLEAR)) |=> busy, "busy dropped after clear request")

endmodule

@@ rtl/acet_overlap.sv @@
module acet_overlap (
    input  acet_pkg::req_t request,
    output logic           hit
);
    import acet_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int TW = COORD_BITS + 2;

    // 2*|a-b| < sa+sb, exact in integers
    function automatic logic axis_hit(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic [SIZE_BITS-1:0]         sa,
        input logic [SIZE_BITS-1:0]         sb
    );
        logic signed [DW-1:0] diff;
        logic [DW-1:0]        mag;
        logic [TW-1:0]        twice;
        logic [TW-1:0]        span;
        diff  = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        mag   = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
        twice = {mag, 1'b0};
        span  = TW'(sa) + TW'(sb);
        return twice < span;
    endfunction

    assign hit = axis_hit(request.first_x, request.second_x, request.first_w, request.second_w)
              && axis_hit(request.first_y, request.second_y, request.first_h, request.second_h);

endmodule

@@ sim/tb_aabb_contact_event_tracker.sv @@
`timescale 1ns / 100ps

// Testbench for the contact event tracker.
// Requests go in on start/busy; each one yields one result on done/result,
// which cannot be held off. A scoreboard object keeps its own touching bits
// and predicts every result from the accepted requests.
module tb_aabb_contact_event_tracker;

    import acet_pkg::*;

    localparam int PAIR_SIDE      = DEF_MAX_COLLIDERS;
    localparam int RANDOM_PER_RUN = 150;    // random requests per idling phase
    localparam int MAX_GAP        = 30;     // longest sender gap, in cycles
    // A clear holds busy while its 128 rows are swept; add the longest gap
    // and the pipeline, then leave a wide margin.
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int REPORT_LIMIT   = 10;

    // ------------------------------------------------------------------
    // Contact scoreboard: mirrors the per-pair touching bits and queues the
    // event expected for every accepted request.
    // ------------------------------------------------------------------
    class contact_scoreboard;
        bit   touching [PAIR_SIDE][PAIR_SIDE];
        res_t expected_q [$];
        int   mismatches;

        function new();
            mismatches = 0;
            foreach (touching[i, j])
                touching[i][j] = 1'b0;
        endfunction

        // 2*|c1-c2| < s1+s2 on both axes, exact in 32-bit integers.
        function bit boxes_overlap(req_t r);
            int dx;
            int dy;
            int sum_w;
            int sum_h;
            dx    = $signed(r.first_x) - $signed(r.second_x);
            dy    = $signed(r.first_y) - $signed(r.second_y);
            sum_w = r.first_w + r.second_w;
            sum_h = r.first_h + r.second_h;
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            return (2 * dx < sum_w) && (2 * dy < sum_h);
        endfunction

        function void note_request(req_t r);
            res_t want;
            bit   was;
            want = '0;
            if (r.kind == KIND_CLEAR)
            begin
                foreach (touching[i, j])
                    touching[i][j] = 1'b0;
            end
            else
            begin
                want.overlapping = boxes_overlap(r);
                want.event_res   = EV_NONE;
                // equal ids never touch the stored bits
                if (r.first_id != r.second_id)
                begin
                    was = touching[r.first_id][r.second_id];
                    if (want.overlapping)
                    begin
                        want.event_res = was ? EV_STAY : EV_ENTER;
                        touching[r.first_id][r.second_id] = 1'b1;
                    end
                    else if (was)
                    begin
                        want.event_res = EV_EXIT;
                        touching[r.first_id][r.second_id] = 1'b0;
                    end
                end
            end
            expected_q.push_back(want);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result with no request pending: event %0d ovl %0b",
                             $time, got.event_res, got.overlapping);
                return;
            end
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res || got.overlapping !== want.overlapping)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] mismatch: exp event %0d ovl %0b, got event %0d ovl %0b",
                             $time, want.event_res, want.overlapping,
                             got.event_res, got.overlapping);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    res_t result;

    contact_scoreboard contacts;
    int stall_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    aabb_contact_event_tracker DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the NBA
    // updates of that edge land, so DUT and driver values are both the
    // ones that were stable during the cycle. Results are checked ahead of
    // noting a new request, since a request cannot answer in its own cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                contacts.check_result(result);
            if (start && !busy)
                contacts.note_request(request);
        end
    end

    // Watchdog: cycles with neither a request taken nor a result out.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic req_t pair_test(int a, int b, int x1, int y1, int w1, int h1,
                                       int x2, int y2, int w2, int h2);
        req_t r;
        r.kind      = KIND_TEST;
        r.first_id  = ID_BITS'(a);
        r.second_id = ID_BITS'(b);
        r.first_x   = COORD_BITS'(x1);
        r.first_y   = COORD_BITS'(y1);
        r.first_w   = SIZE_BITS'(w1);
        r.first_h   = SIZE_BITS'(h1);
        r.second_x  = COORD_BITS'(x2);
        r.second_y  = COORD_BITS'(y2);
        r.second_w  = SIZE_BITS'(w2);
        r.second_h  = SIZE_BITS'(h2);
        return r;
    endfunction

    // A pair test with any value in every other field; covers every bit of those fields.
    function automatic req_t noise_request();
        return pair_test($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic req_t clear_request();
        req_t r;
        r      = noise_request();
        r.kind = KIND_CLEAR;
        return r;
    endfunction

    // Mostly well-formed pair tests: a small id pool so pairs recur and walk
    // through enter / stay / exit, boxes placed close so overlap is a coin
    // toss. The rest is full-range noise, equal ids and rare clears.
    function automatic req_t random_request();
        int roll;
        int a;
        int b;
        int cx;
        int cy;
        int w1;
        int h1;
        int w2;
        int h2;
        roll = $urandom_range(99, 0);
        if (roll < 2)
            return clear_request();
        if (roll < 14)
            return noise_request();
        a = $urandom_range(5, 0);
        b = (roll < 19) ? a : $urandom_range(5, 0);
        if (roll >= 97)
        begin
            // pool at the top end of the id range
            a = a + 58;
            b = b + 58;
        end
        cx = $urandom;
        cy = $urandom;
        w1 = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(255, 0);
        h1 = $urandom_range(255, 0);
        w2 = $urandom_range(255, 0);
        h2 = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(255, 0);
        return pair_test(a, b, cx, cy, w1, h1,
                         cx + int'($urandom_range(320, 0)) - 160,
                         cy + int'($urandom_range(320, 0)) - 160, w2, h2);
    endfunction

    // ------------------------------------------------------------------
    // Driver. Called at a rising edge; returns at the edge where the request
    // was taken. A gap lowers start first; with no gap start stays high.
    // ------------------------------------------------------------------
    task automatic send_request(input req_t r, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99, 0) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Directed opening: the event walk on one pair, the reverse ordered
    // pair, strict-compare boundaries, equal ids, zero sizes, coordinate and
    // size extremes, id extremes, and clears right behind tests.
    task automatic run_directed(input int idle_pct);
        send_request(pair_test(1, 2, 0, 0, 32, 32, 16, 16, 32, 32), idle_pct);   // enter
        send_request(pair_test(1, 2, 0, 0, 32, 32, 16, 16, 32, 32), idle_pct);   // stay
        send_request(pair_test(2, 1, 0, 0, 32, 32, 16, 16, 32, 32), idle_pct);   // own bit: enter
        send_request(pair_test(1, 2, 0, 0, 32, 32, 32, 0, 32, 32), idle_pct);    // edge touch: exit
        send_request(pair_test(1, 2, 0, 0, 32, 32, 32, 0, 32, 32), idle_pct);    // none
        send_request(pair_test(1, 2, 0, 0, 32, 32, 31, -31, 32, 32), idle_pct);  // just inside
        send_request(pair_test(1, 2, 0, 0, 32, 32, 0, -32, 32, 32), idle_pct);   // y edge: exit
        send_request(pair_test(7, 7, 5, 5, 40, 40, 5, 5, 40, 40), idle_pct);     // equal ids
        send_request(pair_test(0, 0, 0, 0, 1, 1, 900, 900, 1, 1), idle_pct);
        send_request(pair_test(3, 4, 100, 100, 0, 0, 100, 100, 0, 0), idle_pct); // zero sizes
        send_request(pair_test(3, 4, 0, 0, 0, 0, 0, 0, 1, 1), idle_pct);
        send_request(pair_test(0, 63, -32768, -32768, 32767, 32767,
                               32767, 32767, 32767, 32767), idle_pct);           // full span
        send_request(pair_test(63, 0, 32767, -32768, 32767, 32767,
                               32767, -32768, 32767, 32767), idle_pct);          // max sizes
        send_request(pair_test(63, 0, -32768, 32767, 1, 1, 32767, -32768, 1, 1), idle_pct);
        send_request(clear_request(), idle_pct);
        send_request(pair_test(1, 2, 0, 0, 32, 32, 16, 16, 32, 32), idle_pct);   // enter again
        send_request(pair_test(2, 1, 0, 0, 32, 32, 16, 16, 32, 32), idle_pct);
        send_request(pair_test(62, 63, 10, 10, 8, 8, 10, 10, 8, 8), idle_pct);
        send_request(clear_request(), 0);                                        // right behind
        send_request(clear_request(), 0);
        send_request(pair_test(62, 63, 10, 10, 8, 8, 10, 10, 8, 8), 0);          // enter
        send_request(pair_test(62, 63, 10, 10, 8, 8, 20, 10, 8, 8), 0);          // same row: exit
        send_request(pair_test(63, 62, 10, 10, 8, 8, 10, 10, 8, 8), 0);
        send_request(pair_test(63, 62, 10, 10, 8, 8, 10, 10, 8, 8), 0);          // stay
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset (the DUT then sweeps its RAM with busy high),
    // directed requests, then random requests under three idling mixes.
    // ------------------------------------------------------------------
    initial
    begin
        contacts = new();
        start   <= 1'b0;
        request <= '0;
        rst_n   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n   <= 1'b1;

        run_directed(16);
        repeat (RANDOM_PER_RUN) send_request(random_request(), 16);
        repeat (RANDOM_PER_RUN) send_request(random_request(), 54);
        repeat (RANDOM_PER_RUN) send_request(random_request(), 0);
        start <= 1'b0;

        // drain, then keep the clock running to catch stray results
        while (contacts.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (contacts.mismatches == 0 && contacts.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
